FILE: hw/rtl/ccsk_pkg.sv
// ----------------------------------------------------------------------------
// ccsk_pkg
// Shared types, key codes and calendar helpers for the calendar clock.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsk_pkg;

    localparam int KeyWidth  = 5;
    localparam int YearWidth = 14;

    // Keypad codes (row*4+col+1)
    localparam logic [KeyWidth-1:0] KEY_YEAR_DN   = 5'd1;
    localparam logic [KeyWidth-1:0] KEY_YEAR_UP   = 5'd2;
    localparam logic [KeyWidth-1:0] KEY_HOUR_UP   = 5'd3;
    localparam logic [KeyWidth-1:0] KEY_HOUR_DN   = 5'd4;
    localparam logic [KeyWidth-1:0] KEY_MONTH_UP  = 5'd5;
    localparam logic [KeyWidth-1:0] KEY_MONTH_DN  = 5'd6;
    localparam logic [KeyWidth-1:0] KEY_MINUTE_UP = 5'd7;
    localparam logic [KeyWidth-1:0] KEY_MINUTE_DN = 5'd8;
    localparam logic [KeyWidth-1:0] KEY_DAY_UP    = 5'd9;
    localparam logic [KeyWidth-1:0] KEY_DAY_DN    = 5'd10;
    localparam logic [KeyWidth-1:0] KEY_SECOND_UP = 5'd11;
    localparam logic [KeyWidth-1:0] KEY_SECOND_DN = 5'd12;
    localparam logic [KeyWidth-1:0] KEY_PRESET    = 5'd13;
    localparam logic [KeyWidth-1:0] KEY_SET_ENTER = 5'd14;
    localparam logic [KeyWidth-1:0] KEY_SET_LEAVE = 5'd15;
    localparam logic [KeyWidth-1:0] KEY_BLINK     = 5'd16;
    // Same position as minute down, used in run mode
    localparam logic [KeyWidth-1:0] KEY_24H       = 5'd8;

    // Preset time
    localparam logic [YearWidth-1:0] PRESET_YEAR   = 14'd2016;
    localparam logic [3:0]           PRESET_MONTH  = 4'd2;
    localparam logic [4:0]           PRESET_DAY    = 5'd28;
    localparam logic [4:0]           PRESET_HOUR   = 5'd23;
    localparam logic [5:0]           PRESET_MINUTE = 6'd59;
    localparam logic [5:0]           PRESET_SECOND = 6'd50;

    localparam logic [YearWidth-1:0] YEAR_LIMIT = 14'd10000;

    // Result payload; first declared member sits in the highest bits
    typedef struct packed {
        logic                 in_adjust;
        logic                 colon_visible;
        logic                 show_24h;
        logic                 is_pm;
        logic [3:0]           hour_twelve;
        logic [5:0]           second;
        logic [5:0]           minute;
        logic [4:0]           hour;
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YearWidth-1:0] year;
    } result_t;

    // Gregorian leap year; divisibility by 25 through a reciprocal multiply
    function automatic logic is_leap(input logic [YearWidth-1:0] y);
        logic [26:0] prod;
        logic [9:0]  quot;
        logic [13:0] rem;
        logic        div25;
        prod  = 27'(y) * 27'd5243;
        quot  = prod[26:17];
        rem   = y - 14'({4'd0, quot} * 14'd25);
        div25 = (rem == 14'd0);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    function automatic logic [5:0] month_len(input logic [3:0] m,
                                             input logic [YearWidth-1:0] y);
        logic [5:0] len;
        case (m)
            4'd2:                      len = is_leap(y) ? 6'd29 : 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 6'd30;
            default:                   len = 6'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/calendar_clock_with_set_keys.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_set_keys
// Tick-driven calendar clock with keypad set mode and display flags.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one tick; s_tdata[4:0] carries the key
//   code pressed during that tick (0 for none). The block applies the key,
//   normalizes the date and time, and returns one result on the m_ channel
//   with the date, time, 12-hour form and display flags, then advances the
//   time by one second for the next tick.
// Latency and throughput:
//   A result is valid the cycle after its request is accepted when the
//   result register is empty or draining; otherwise it waits in the skid
//   register. One request is taken every cycle while s_tready is high; the
//   key decode, one carry pass and the leap-year check fit between the state
//   registers and the result register.
// Reset:
//   rst_n loads the preset time (2016-02-28 23:59:50), run mode, 24-hour
//   display on, blinking off. Both channels come up empty and s_tready high.
// Stall:
//   A two-entry output (result register plus skid register) keeps taking
//   requests while one result waits; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_with_set_keys
    import ccsk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [4:0] key, [7:5] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
    // [39:34] second, [43:40] hour_twelve, [44] is_pm, [45] show_24h,
    // [46] colon_visible, [47] in_adjust
    output logic [47:0]      m_tdata
);

    logic [YearWidth-1:0] year_reg,   year_next;
    logic [3:0]           month_reg,  month_next;
    logic [4:0]           day_reg,    day_next;
    logic [4:0]           hour_reg,   hour_next;
    logic [5:0]           minute_reg, minute_next;
    logic [5:0]           second_reg, second_next;
    logic                 adjust_reg, adjust_next;
    logic                 mode_24h_reg, mode_24h_next;
    logic                 blink_en_reg, blink_en_next;
    logic                 blink_ph_reg, blink_ph_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    result_t res;

    logic [KeyWidth-1:0] key;
    logic                accept, drain;

    // Working values, one bit wider where a step can overshoot
    logic [YearWidth-1:0] yr;
    logic [3:0]           mo;
    logic [5:0]           dy;
    logic [4:0]           hr;
    logic [5:0]           mi;
    logic [5:0]           se;
    logic [5:0]           len;
    logic                 colon;
    logic [4:0]           h_mod;

    assign key      = s_tdata[KeyWidth-1:0];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign drain    = out_valid_reg && m_tready;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        yr = year_reg;
        mo = month_reg;
        dy = {1'b0, day_reg};
        hr = hour_reg;
        mi = minute_reg;
        se = second_reg;
        adjust_next   = adjust_reg;
        mode_24h_next = mode_24h_reg;
        blink_en_next = blink_en_reg;

        if (adjust_reg)
        begin
            unique case (key)
                KEY_YEAR_DN:   if (yr != '0)         yr = yr - 14'd1;
                KEY_YEAR_UP:   if (yr < YEAR_LIMIT)  yr = yr + 14'd1;
                KEY_HOUR_UP:   hr = hr + 5'd1;
                KEY_HOUR_DN:   if (hr != '0)         hr = hr - 5'd1;
                KEY_MONTH_UP:  mo = mo + 4'd1;
                KEY_MONTH_DN:  if (mo > 4'd1)        mo = mo - 4'd1;
                KEY_MINUTE_UP: mi = mi + 6'd1;
                KEY_MINUTE_DN: if (mi != '0)         mi = mi - 6'd1;
                KEY_DAY_UP:    dy = dy + 6'd1;
                KEY_DAY_DN:    if (dy > 6'd1)        dy = dy - 6'd1;
                KEY_SECOND_UP: se = se + 6'd1;
                KEY_SECOND_DN: if (se != '0)         se = se - 6'd1;
                KEY_SET_LEAVE:
                begin
                    adjust_next = 1'b0;
                    se          = '0;
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (key)
                KEY_SET_ENTER: adjust_next = 1'b1;
                KEY_PRESET:
                begin
                    yr = PRESET_YEAR;
                    mo = PRESET_MONTH;
                    dy = {1'b0, PRESET_DAY};
                    hr = PRESET_HOUR;
                    mi = PRESET_MINUTE;
                    se = PRESET_SECOND;
                end
                KEY_24H:   mode_24h_next = !mode_24h_reg;
                KEY_BLINK: blink_en_next = !blink_en_reg;
                default: ;
            endcase
        end

        // One carry pass normalizes every reachable state
        if (se >= 6'd60)
        begin
            se = se - 6'd60;
            mi = mi + 6'd1;
        end
        if (mi >= 6'd60)
        begin
            mi = mi - 6'd60;
            hr = hr + 5'd1;
        end
        if (hr >= 5'd24)
        begin
            hr = hr - 5'd24;
            dy = dy + 6'd1;
        end
        len = month_len(mo, yr);
        if (dy > len)
        begin
            dy = 6'd1;
            mo = mo + 4'd1;
        end
        if (mo >= 4'd13)
        begin
            mo = 4'd1;
            yr = yr + 14'd1;
        end

        if (blink_en_next)
        begin
            colon         = !blink_ph_reg;
            blink_ph_next = !blink_ph_reg;
        end
        else
        begin
            colon         = 1'b1;
            blink_ph_next = blink_ph_reg;
        end

        h_mod = (hr >= 5'd12) ? hr - 5'd12 : hr;

        res.year          = yr;
        res.month         = mo;
        res.day           = dy[4:0];
        res.hour          = hr;
        res.minute        = mi;
        res.second        = se;
        res.hour_twelve   = (h_mod == 5'd0) ? 4'd12 : h_mod[3:0];
        res.is_pm         = (hr >= 5'd12);
        res.show_24h      = mode_24h_next;
        res.colon_visible = colon;
        res.in_adjust     = adjust_next;

        year_next   = yr;
        month_next  = mo;
        day_next    = dy[4:0];
        hour_next   = hr;
        minute_next = mi;
        // Advance one second; the next carry pass folds 60 back
        second_next = se + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg       <= PRESET_YEAR;
            month_reg      <= PRESET_MONTH;
            day_reg        <= PRESET_DAY;
            hour_reg       <= PRESET_HOUR;
            minute_reg     <= PRESET_MINUTE;
            second_reg     <= PRESET_SECOND;
            adjust_reg     <= 1'b0;
            mode_24h_reg   <= 1'b1;
            blink_en_reg   <= 1'b0;
            blink_ph_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                year_reg     <= year_next;
                month_reg    <= month_next;
                day_reg      <= day_next;
                hour_reg     <= hour_next;
                minute_reg   <= minute_next;
                second_reg   <= second_next;
                adjust_reg   <= adjust_next;
                mode_24h_reg <= mode_24h_next;
                blink_en_reg <= blink_en_next;
                blink_ph_reg <= blink_ph_next;
            end

            if (skid_valid_reg)
            begin
                if (drain)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !drain)
                begin
                    skid_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (drain)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ccsk_checker.sv
// ----------------------------------------------------------------------------
// ccsk_checker
// Port-level checks for the calendar clock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsk_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

    // An accepted request is followed by m_tvalid high on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request gave no result");

    // Input backpressure only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("s_tready low with empty output");

    // Backpressure only follows a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready && s_tvalid))
    else $error("s_tready dropped without a stall");

endmodule

bind calendar_clock_with_set_keys ccsk_checker u_ccsk_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
